@@ rtl/fdl_pkg.sv @@
// shared types and constants for the directory entry name lookup
package fdl_pkg;

    localparam int unsigned ENTRY_OFF_W = 5;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [7:0] DELETED_MARK  = 8'hE5;
    localparam logic [3:0] LFN_ATTR_MASK = 4'hF;

    localparam logic [ENTRY_OFF_W-1:0] OFF_FIRST    = 5'd0;
    localparam logic [ENTRY_OFF_W-1:0] OFF_NAME_END = 5'd11;
    localparam logic [ENTRY_OFF_W-1:0] OFF_ATTR     = 5'd11;
    localparam logic [ENTRY_OFF_W-1:0] OFF_CLUS_HI0 = 5'd20;
    localparam logic [ENTRY_OFF_W-1:0] OFF_CLUS_HI1 = 5'd21;
    localparam logic [ENTRY_OFF_W-1:0] OFF_CLUS_LO0 = 5'd26;
    localparam logic [ENTRY_OFF_W-1:0] OFF_CLUS_LO1 = 5'd27;
    localparam logic [ENTRY_OFF_W-1:0] OFF_SIZE0    = 5'd28;
    localparam logic [ENTRY_OFF_W-1:0] OFF_LAST     = 5'd31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NAME_LOW  = 1'b0,
        CFG_NAME_HIGH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic differs;
        logic settled;
    } cmp_flags_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  attributes;
        logic [31:0] start_cluster;
        logic [31:0] file_size;
    } result_t;

endpackage

@@ rtl/fat_dir_entry_name_lookup_core.sv @@
// top level of the directory entry name lookup
//
// Directory bytes arrive on the input channel (in_valid / in_stall), one byte
// per transfer, with start_scan marking the first byte of a scan and last_byte
// the final byte of the directory. Each byte is consumed in the cycle it is
// transferred: the entry offset, compare flags and captured fields update at
// that edge, and any result is registered for the output channel (out_valid /
// out_stall) in the same edge. Throughput is one byte per cycle while in_stall
// is low; the only loop is the per-byte state update. The requested name is
// written on the configuration channel (cfg_valid / cfg_ready, always ready);
// the user must write it only while no scan is running; it is not enforced.
// Index 0 takes name bytes 0 to 7, index 1 bytes 8 to 10 from cfg_data[23:0].
// A result waiting under out_stall does not block input: a second result goes
// to a one-entry skid register, and in_stall rises only while that is full.
// After reset the block is idle and ignores bytes until one with start_scan;
// the name registers clear to zero.
module fat_dir_entry_name_lookup_core
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     entry_byte,
    input  logic                           start_scan,
    input  logic                           last_byte,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           found,
    output logic [7:0]                     attributes,
    output logic [31:0]                    start_cluster,
    output logic [31:0]                    file_size,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fdl_pkg::*;

    // configuration
    logic [63:0] name_low_reg;
    logic [23:0] name_high_reg;

    // scan control state
    logic [ENTRY_OFF_W-1:0] offset_reg, offset_next;
    cmp_flags_t             flags_reg, flags_next;
    logic                   skipped_reg, skipped_next;
    logic                   finished_reg, finished_next;

    // captured entry fields
    logic [7:0]  attr_reg, attr_next;
    logic [15:0] clus_hi_reg, clus_hi_next;
    logic [15:0] clus_lo_reg, clus_lo_next;
    logic [31:0] size_reg, size_next;

    // output side
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_reg, skid_next;

    logic                   accept;
    logic                   active;
    logic [ENTRY_OFF_W-1:0] off_cur;
    cmp_flags_t             flags_cur;
    cmp_flags_t             flags_new;
    logic                   skipped_cur;
    logic                   res_valid;
    result_t                res;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = skid_valid_reg;
    assign cfg_ready = 1'b1;

    // a start byte clears the entry state before it is processed
    assign active      = start_scan || !finished_reg;
    assign off_cur     = start_scan ? OFF_FIRST : offset_reg;
    assign flags_cur   = start_scan ? cmp_flags_t'('0) : flags_reg;
    assign skipped_cur = start_scan ? 1'b0 : skipped_reg;

    fdl_name_cmp u_name_cmp
    (
        .offset     (off_cur),
        .entry_byte (entry_byte),
        .name_low   (name_low_reg),
        .name_high  (name_high_reg),
        .flags_cur  (flags_cur),
        .flags_new  (flags_new)
    );

    always_comb
    begin
        offset_next   = offset_reg;
        flags_next    = flags_reg;
        skipped_next  = skipped_reg;
        finished_next = finished_reg;
        attr_next     = attr_reg;
        clus_hi_next  = clus_hi_reg;
        clus_lo_next  = clus_lo_reg;
        size_next     = size_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (accept && active)
        begin
            offset_next   = off_cur;
            flags_next    = flags_cur;
            skipped_next  = skipped_cur;
            finished_next = 1'b0;

            if ((off_cur == OFF_FIRST) && (entry_byte == 8'h00))
            begin
                // end marker
                res_valid     = 1'b1;
                finished_next = 1'b1;
            end
            else
            begin
                flags_next = flags_new;
                if ((off_cur == OFF_FIRST) && (entry_byte == DELETED_MARK))
                begin
                    skipped_next = 1'b1;
                end
                if (off_cur == OFF_ATTR)
                begin
                    attr_next = entry_byte;
                    if ((entry_byte[3:0] & LFN_ATTR_MASK) == LFN_ATTR_MASK)
                    begin
                        skipped_next = 1'b1;
                    end
                end
                if (off_cur == OFF_CLUS_HI0)
                begin
                    clus_hi_next[7:0] = entry_byte;
                end
                if (off_cur == OFF_CLUS_HI1)
                begin
                    clus_hi_next[15:8] = entry_byte;
                end
                if (off_cur == OFF_CLUS_LO0)
                begin
                    clus_lo_next[7:0] = entry_byte;
                end
                if (off_cur == OFF_CLUS_LO1)
                begin
                    clus_lo_next[15:8] = entry_byte;
                end
                if (off_cur >= OFF_SIZE0)
                begin
                    size_next[{off_cur[1:0], 3'b000} +: 8] = entry_byte;
                end

                offset_next = off_cur + 1'b1;

                if ((off_cur == OFF_LAST) && !skipped_next && !flags_next.differs)
                begin
                    res_valid           = 1'b1;
                    res.found           = 1'b1;
                    res.attributes      = attr_next;
                    res.start_cluster   = {clus_hi_next, clus_lo_next};
                    res.file_size       = size_next;
                    finished_next       = 1'b1;
                end
                else
                begin
                    if (off_cur == OFF_LAST)
                    begin
                        flags_next   = '0;
                        skipped_next = 1'b0;
                    end
                    if (last_byte)
                    begin
                        res_valid     = 1'b1;
                        finished_next = 1'b1;
                    end
                end
            end
        end
    end

    // output register with one skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_low_reg   <= '0;
            name_high_reg  <= '0;
            offset_reg     <= '0;
            flags_reg      <= '0;
            skipped_reg    <= 1'b0;
            finished_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_NAME_LOW:  name_low_reg  <= cfg_data[63:0];
                    CFG_NAME_HIGH: name_high_reg <= cfg_data[23:0];
                    default:       name_low_reg  <= name_low_reg;
                endcase
            end
            offset_reg     <= offset_next;
            flags_reg      <= flags_next;
            skipped_reg    <= skipped_next;
            finished_reg   <= finished_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers, every field is rewritten before it is reported
    always_ff @(posedge clk)
    begin
        attr_reg    <= attr_next;
        clus_hi_reg <= clus_hi_next;
        clus_lo_reg <= clus_lo_next;
        size_reg    <= size_next;
        out_reg     <= out_next;
        skid_reg    <= skid_next;
    end

    assign out_valid     = out_valid_reg;
    assign found         = out_reg.found;
    assign attributes    = out_reg.attributes;
    assign start_cluster = out_reg.start_cluster;
    assign file_size     = out_reg.file_size;

endmodule

@@ rtl/fdl_name_cmp.sv @@
// per-byte name comparison with strncmp stop on an equal zero byte
module fdl_name_cmp
(
    input  logic [fdl_pkg::ENTRY_OFF_W-1:0] offset,
    input  logic [7:0]                      entry_byte,
    input  logic [63:0]                     name_low,
    input  logic [23:0]                     name_high,
    input  fdl_pkg::cmp_flags_t             flags_cur,
    output fdl_pkg::cmp_flags_t             flags_new
);
    import fdl_pkg::*;

    logic [7:0] req_byte;

    always_comb
    begin
        if (offset[4:3] == 2'b00)
        begin
            req_byte = name_low[{offset[2:0], 3'b000} +: 8];
        end
        else
        begin
            unique case (offset[1:0])
                2'd0:    req_byte = name_high[7:0];
                2'd1:    req_byte = name_high[15:8];
                2'd2:    req_byte = name_high[23:16];
                default: req_byte = 8'h00;
            endcase
        end
    end

    always_comb
    begin
        flags_new = flags_cur;
        if ((offset < OFF_NAME_END) && !flags_cur.differs && !flags_cur.settled)
        begin
            if (entry_byte != req_byte)
            begin
                flags_new.differs = 1'b1;
            end
            else if (entry_byte == 8'h00)
            begin
                flags_new.settled = 1'b1;
            end
        end
    end

endmodule

@@ verif/fdl_lookup_checker.sv @@
// checker for the directory entry name lookup: predicts each result from the observed transfers
`timescale 1ns / 100ps
module fdl_lookup_checker
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [7:0]                     entry_byte,
    input  logic                           start_scan,
    input  logic                           last_byte,

    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           found,
    input  logic [7:0]                     attributes,
    input  logic [31:0]                    start_cluster,
    input  logic [31:0]                    file_size,

    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0] cfg_data,

    output int                             fail_count,
    output int                             pending
);
    import fdl_pkg::*;

    logic [63:0]            req_low;
    logic [23:0]            req_high;
    logic [ENTRY_OFF_W-1:0] pos_q;
    logic                   differs_q;
    logic                   settled_q;
    logic                   skipped_q;
    logic                   idle_q;
    logic [7:0]             attr_q;
    logic [15:0]            clus_hi_q;
    logic [15:0]            clus_lo_q;
    logic [31:0]            size_q;
    result_t                lookup_q[$];

    function automatic logic [7:0] wanted_byte(input logic [ENTRY_OFF_W-1:0] k);
        if (k < 8)
            return req_low[8*k +: 8];
        return req_high[8*(k-8) +: 8];
    endfunction

    function automatic void clear_fields();
        differs_q = 1'b0;
        settled_q = 1'b0;
        skipped_q = 1'b0;
        attr_q    = '0;
        clus_hi_q = '0;
        clus_lo_q = '0;
        size_q    = '0;
    endfunction

    // advances the scan by one directory byte, returns 1 when the scan ends here
    function automatic bit scan_byte(input logic [7:0] b, input logic s, input logic l,
                                     output result_t r);
        logic [ENTRY_OFF_W-1:0] pos;
        r = '0;
        if (s)
        begin
            pos_q  = OFF_FIRST;
            idle_q = 1'b0;
            clear_fields();
        end
        if (idle_q)
            return 1'b0;
        pos = pos_q;
        // end marker: not found, whatever the requested name
        if (pos == OFF_FIRST && b == 8'h00)
        begin
            idle_q = 1'b1;
            return 1'b1;
        end
        if (pos == OFF_FIRST && b == DELETED_MARK)
            skipped_q = 1'b1;
        // strncmp rules: an equal zero byte settles the compare
        if (pos < OFF_NAME_END && !differs_q && !settled_q)
        begin
            if (b != wanted_byte(pos))
                differs_q = 1'b1;
            else if (b == 8'h00)
                settled_q = 1'b1;
        end
        if (pos == OFF_ATTR)
        begin
            attr_q = b;
            if (b[3:0] == LFN_ATTR_MASK)
                skipped_q = 1'b1;
        end
        case (pos)
            OFF_CLUS_HI0: clus_hi_q[7:0]  = b;
            OFF_CLUS_HI1: clus_hi_q[15:8] = b;
            OFF_CLUS_LO0: clus_lo_q[7:0]  = b;
            OFF_CLUS_LO1: clus_lo_q[15:8] = b;
            default: ;
        endcase
        if (pos >= OFF_SIZE0)
            size_q[8*(pos-OFF_SIZE0) +: 8] = b;
        pos_q = pos + 1'b1;
        if (pos == OFF_LAST)
        begin
            if (!skipped_q && !differs_q)
            begin
                r.found         = 1'b1;
                r.attributes    = attr_q;
                r.start_cluster = {clus_hi_q, clus_lo_q};
                r.file_size     = size_q;
                idle_q          = 1'b1;
                return 1'b1;
            end
            clear_fields();
        end
        if (l)
        begin
            idle_q = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            req_low  = '0;
            req_high = '0;
            pos_q    = OFF_FIRST;
            idle_q   = 1'b1;
            clear_fields();
            lookup_q.delete();
            pending <= 0;
        end
        else
        begin
            // results are registered, so the output side is checked before this edge's input
            if (out_valid && !out_stall)
            begin
                got.found         = found;
                got.attributes    = attributes;
                got.start_cluster = start_cluster;
                got.file_size     = file_size;
                if (lookup_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: found %0d attributes %0h",
                           got.found, got.attributes);
                    fail_count++;
                end
                else
                begin
                    want = lookup_q.pop_front();
                    if (got.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, got.found);
                        fail_count++;
                    end
                    if (got.attributes !== want.attributes)
                    begin
                        $error("attributes: expected %0h, got %0h",
                               want.attributes, got.attributes);
                        fail_count++;
                    end
                    if (got.start_cluster !== want.start_cluster)
                    begin
                        $error("start_cluster: expected %0h, got %0h",
                               want.start_cluster, got.start_cluster);
                        fail_count++;
                    end
                    if (got.file_size !== want.file_size)
                    begin
                        $error("file_size: expected %0h, got %0h",
                               want.file_size, got.file_size);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NAME_LOW)
                    req_low = cfg_data;
                else if (cfg_index == CFG_NAME_HIGH)
                    req_high = cfg_data[23:0];
            end
            if (in_valid && !in_stall)
            begin
                if (scan_byte(entry_byte, start_scan, last_byte, want))
                    lookup_q.push_back(want);
            end
            pending <= lookup_q.size();
        end
    end

endmodule

@@ verif/tb_fat_dir_entry_name_lookup_core.sv @@
// testbench top: directory byte stimulus, name setup, output stalling and verdict
`timescale 1ns / 100ps
module tb_fat_dir_entry_name_lookup_core;
    import fdl_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 4;
    localparam int PHASES          = 5;
    localparam int SCANS_PER_PHASE = 2;

    typedef enum logic [2:0] {
        NAME_ALL_ONES,
        NAME_EMPTY,
        NAME_SHORT,
        NAME_CUT,
        NAME_RANDOM
    } name_style_t;

    typedef enum logic [2:0] {
        ENT_MATCH,
        ENT_NEAR,
        ENT_DELETED,
        ENT_LONGNAME,
        ENT_RANDOM
    } entry_kind_t;

    typedef enum logic [1:0] {
        END_AT_LAST,
        END_MARKER,
        END_MID,
        END_RESTART
    } scan_end_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            entry_byte;
    logic                  start_scan;
    logic                  last_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic                  found;
    logic [7:0]            attributes;
    logic [31:0]           start_cluster;
    logic [31:0]           file_size;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    logic [7:0] want_name [11];
    logic [7:0] ent [32];
    bit         tx_no_gaps = 1'b0;
    bit         rx_no_stall = 1'b0;
    bit         squeezing = 1'b0;
    bit         hold_req = 1'b0;
    int         quiet = 0;

    fat_dir_entry_name_lookup_core dut (.*);

    fdl_lookup_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // no transfer of any kind for too long means the block has hung
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_CYCLES)
        begin
            $display("tb_fat_dir_entry_name_lookup_core NOT OK");
            $finish;
        end
    end

    // result side: random stall before each transfer, one long hold on request
    initial
    begin : result_side
        int k;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 24) == 0)
                    rx_no_stall = !rx_no_stall;
                k = rx_no_stall ? 0 : $urandom_range(0, 13);
                if (k > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (k) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic s, input logic l);
        int gap;
        if (!squeezing && $urandom_range(0, 24) == 0)
            tx_no_gaps = !tx_no_gaps;
        gap = (tx_no_gaps || squeezing) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        entry_byte <= b;
        start_scan <= s;
        last_byte  <= l;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // wait until every result is out and the block is idle again
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_name();
        logic [63:0] lo;
        logic [23:0] hi;
        for (int k = 0; k < 8; k++)
            lo[8*k +: 8] = want_name[k];
        for (int k = 0; k < 3; k++)
            hi[8*k +: 8] = want_name[8+k];
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NAME_LOW;
        cfg_data  <= lo;
        do
            @(posedge clk);
        while (!cfg_ready);
        // upper bits of the name_high write carry junk, they must be ignored
        cfg_index <= CFG_NAME_HIGH;
        cfg_data  <= {32'($urandom), 8'($urandom), hi};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_name(input name_style_t style);
        int cut;
        for (int k = 0; k < 11; k++)
            want_name[k] = 8'($urandom);
        case (style)
            NAME_ALL_ONES:
                for (int k = 0; k < 11; k++)
                    want_name[k] = 8'hFF;
            NAME_EMPTY:
                for (int k = 0; k < 11; k++)
                    want_name[k] = 8'h00;
            NAME_SHORT:
            begin
                // 8.3 style, base name padded with spaces
                cut = $urandom_range(1, 8);
                for (int k = 0; k < 11; k++)
                    want_name[k] = (k < cut || k >= 8) ? 8'($urandom_range(65, 90)) : 8'h20;
            end
            NAME_CUT:
                want_name[$urandom_range(1, 10)] = 8'h00;
            default: ;
        endcase
    endtask

    function automatic entry_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return ENT_MATCH;
        if (r == 4)
            return ENT_NEAR;
        if (r == 5)
            return ENT_DELETED;
        if (r == 6)
            return ENT_LONGNAME;
        return ENT_RANDOM;
    endfunction

    task automatic build_entry(input entry_kind_t kind);
        int k;
        for (k = 0; k < 32; k++)
            ent[k] = 8'($urandom);
        case (kind)
            ENT_MATCH, ENT_NEAR:
            begin
                // copy up to and including the first zero of the name
                for (k = 0; k < 11; k++)
                begin
                    ent[k] = want_name[k];
                    if (want_name[k] == 8'h00)
                        break;
                end
                if (kind == ENT_NEAR)
                begin
                    k = $urandom_range(0, 10);
                    ent[k] = ent[k] ^ (8'h01 << $urandom_range(0, 7));
                end
                if (ent[OFF_ATTR][3:0] == LFN_ATTR_MASK)
                    ent[OFF_ATTR][0] = 1'b0;
                // push cluster and size to their extremes now and then
                k = $urandom_range(0, 3);
                if (k < 2)
                begin
                    for (int j = OFF_CLUS_HI0; j < 32; j++)
                        ent[j] = (k == 0) ? 8'hFF : 8'h00;
                end
            end
            ENT_DELETED:
                ent[OFF_FIRST] = DELETED_MARK;
            ENT_LONGNAME:
                ent[OFF_ATTR][3:0] = LFN_ATTR_MASK;
            default: ;
        endcase
    endtask

    task automatic run_scan(input bit may_restart);
        int        n;
        int        cut;
        scan_end_t how;
        bit        lead;
        bit        tail;
        n    = $urandom_range(1, 2);
        how  = scan_end_t'($urandom_range(0, may_restart ? 3 : 2));
        lead = 1'b1;
        for (int e = 0; e < n; e++)
        begin
            build_entry(pick_kind());
            cut = 31;
            if (e == n - 1 && (how == END_MID || how == END_RESTART))
                cut = $urandom_range(0, 31);
            for (int k = 0; k <= cut; k++)
            begin
                tail = (e == n - 1) && (k == cut) && (how == END_AT_LAST || how == END_MID);
                push_byte(ent[k], lead, tail);
                lead = 1'b0;
            end
        end
        if (how == END_MARKER)
            push_byte(8'h00, 1'b0, 1'b0);
    endtask

    // results pile up behind a long output hold until the input stalls
    task automatic squeeze();
        hold_req  = 1'b1;
        squeezing = 1'b1;
        for (int k = 0; k < 24; k++)
        begin
            if (k % 2 == 0)
                push_byte(8'($urandom_range(1, 255)), 1'b1, 1'b1);
            else
                push_byte(8'h00, 1'b1, 1'b0);
        end
        squeezing = 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        entry_byte = '0;
        start_scan = 1'b0;
        last_byte  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_NAME_LOW;
        cfg_data   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle bytes, end marker on an empty name, restart, short scans
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b1);
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b1);
        push_byte(8'h41, 1'b1, 1'b0);
        push_byte(8'h42, 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(DELETED_MARK, 1'b1, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b1);
        push_byte(8'h01, 1'b1, 1'b1);
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(8'hAA, 1'b1, 1'b0);
        push_byte(8'h00, 1'b1, 1'b1);
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            pick_name(name_style_t'(ph % 5));
            load_name();
            for (int s = 0; s < SCANS_PER_PHASE; s++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    for (int k = $urandom_range(1, 2); k > 0; k--)
                        push_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
                end
                run_scan(s != SCANS_PER_PHASE - 1);
            end
            if (ph == 4)
                squeeze();
            settle();
        end

        if (fail_count == 0)
            $display("tb_fat_dir_entry_name_lookup_core OK");
        else
            $display("tb_fat_dir_entry_name_lookup_core NOT OK");
        $finish;
    end

endmodule
